/* rtl/core/npcm_pkg.sv */
package npcm_pkg;

    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 24;
    localparam int IDX_W   = 8;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 9;
    localparam int SQ_W    = 2 * CHAN_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
    localparam logic [DIST_W-1:0]  MAX_DIST    = DIST_W'(195075);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [RGB_W-1:0]  rgb_value;
    } in_item_t;

    typedef struct packed {
        logic [RGB_W-1:0]  mapped_color;
        logic [IDX_W-1:0]  mapped_index;
        logic [DIST_W-1:0] best_distance;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic last;
        logic busy;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/npcm_ram.sv */
module npcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/npcm_ctrl.sv */
module npcm_ctrl
    import npcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_data,
    output logic     in_stall,
    input  stat_t    status,
    output ctrl_t    ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.cmd == CMD_MAP)
                    begin
                        ctrl.start = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        ctrl.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ctrl.issue = 1'b1;
                if (status.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy && status.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/npcm_dp.sv */
module npcm_dp
    import npcm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_t                ctrl,
    output stat_t                status,
    input  in_item_t             in_data,
    input  logic                 cfg_valid,
    input  logic [COUNT_W-1:0]   cfg_data,
    output out_item_t            out_data,
    output logic                 out_valid,
    input  logic                 out_stall
);

    localparam int AW = $clog2(DEPTH);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] count_lim;
    logic [AW-1:0]      last_idx_reg;
    logic [AW-1:0]      addr_reg;
    logic [RGB_W-1:0]   pixel_reg;

    logic               v_rd_reg;
    logic [AW-1:0]      idx_rd_reg;
    logic [RGB_W-1:0]   rd_color;

    logic               v_sq_reg;
    logic [AW-1:0]      idx_sq_reg;
    logic [RGB_W-1:0]   color_sq_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;
    logic [CHAN_W-1:0]  d_r;
    logic [CHAN_W-1:0]  d_g;
    logic [CHAN_W-1:0]  d_b;

    logic [DIST_W-1:0]  entry_dist;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [RGB_W-1:0]   best_color_reg;

    logic               out_valid_reg;
    out_item_t          out_data_reg;
    logic               wr_en;

    // palette storage
    assign wr_en = ctrl.write && ({1'b0, in_data.entry_index} < COUNT_W'(DEPTH));

    npcm_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (in_data.entry_index[AW-1:0]),
        .wdata (in_data.rgb_value),
        .re    (ctrl.issue),
        .raddr (addr_reg),
        .rdata (rd_color)
    );

    // register write and count clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    assign count_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign count_lim = (count_eff > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : count_eff;

    // scan address
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            pixel_reg    <= in_data.rgb_value;
            addr_reg     <= '0;
            last_idx_reg <= AW'(count_lim - COUNT_W'(1));
        end
        else if (ctrl.issue)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    assign status.last = (addr_reg == last_idx_reg);

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_rd_reg <= 1'b0;
            v_sq_reg <= 1'b0;
        end
        else
        begin
            v_rd_reg <= ctrl.issue;
            v_sq_reg <= v_rd_reg;
        end
    end

    assign status.busy = v_rd_reg || v_sq_reg;

    // channel differences and squares
    always_comb
    begin
        d_r = (pixel_reg[23:16] > rd_color[23:16]) ? pixel_reg[23:16] - rd_color[23:16]
                                                   : rd_color[23:16] - pixel_reg[23:16];
        d_g = (pixel_reg[15:8] > rd_color[15:8]) ? pixel_reg[15:8] - rd_color[15:8]
                                                 : rd_color[15:8] - pixel_reg[15:8];
        d_b = (pixel_reg[7:0] > rd_color[7:0]) ? pixel_reg[7:0] - rd_color[7:0]
                                               : rd_color[7:0] - pixel_reg[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            idx_rd_reg <= addr_reg;
        end
        if (v_rd_reg)
        begin
            idx_sq_reg   <= idx_rd_reg;
            color_sq_reg <= rd_color;
            sq_r_reg     <= SQ_W'(d_r) * SQ_W'(d_r);
            sq_g_reg     <= SQ_W'(d_g) * SQ_W'(d_g);
            sq_b_reg     <= SQ_W'(d_b) * SQ_W'(d_b);
        end
    end

    // sum and keep the first minimum
    assign entry_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_ff @(posedge clk)
    begin
        if (v_sq_reg && ((idx_sq_reg == '0) || (entry_dist < best_dist_reg)))
        begin
            best_dist_reg  <= entry_dist;
            best_idx_reg   <= idx_sq_reg;
            best_color_reg <= color_sq_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg.mapped_color  <= best_color_reg;
            out_data_reg.mapped_index  <= IDX_W'(best_idx_reg);
            out_data_reg.best_distance <= best_dist_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> !v_rd_reg && !v_sq_reg)
        else $error("result loaded while scan pipeline busy");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.write && (ctrl.issue || v_rd_reg || v_sq_reg)))
        else $error("palette write during scan");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.best_distance <= MAX_DIST)
        else $error("distance out of range");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> out_data_reg.mapped_index <= IDX_W'(last_idx_reg))
        else $error("mapped index beyond searched range");

endmodule

/* rtl/core/nearest_palette_color_mapper_core.sv */
// channel   direction   handshake              payload
// in        input       in_valid / in_stall    in_item_t (cmd, entry_index, rgb_value)
// out       output      out_valid / out_stall  out_item_t (color, index, distance)
// cfg       input       cfg_valid / cfg_ready  palette_count, 9 bits
//
// load transaction: written straight into the palette ram
// map transaction: ram read, squares, best match, then output register; next accept once it is loaded,
// the first n entries are searched, n = clamped palette_count, one ram read per entry
// a finished result waits in the output register while loads go on
// the next map transaction stalls at its end until the output register is free
// rst_n clears control and sets palette_count to 1; palette contents stay unknown
module nearest_palette_color_mapper_core
    import npcm_pkg::*;
#(
    parameter int MAX_PALETTE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int DEPTH = (MAX_PALETTE < 256) ? MAX_PALETTE : 256;

    ctrl_t ctrl;
    stat_t status;

    assign cfg_ready = 1'b1;

    npcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    npcm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
